FILE: design/rpct_pkg.sv
`default_nettype none

package rpct_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int NODE_ID_BITS = 20;

    localparam int NODE_W = 20;
    localparam int VAL_W  = 32;
    localparam int SLOT_W = 8;
    localparam int STAT_W = 2;

    // key bits actually compared: the node field is only NODE_W wide
    localparam int KEY_W  = (NODE_ID_BITS < NODE_W) ? NODE_ID_BITS : NODE_W;
    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION = 2'd2;

    localparam logic [STAT_W-1:0] ST_APPEND = 2'd0;
    localparam logic [STAT_W-1:0] ST_UPDATE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic        [NODE_W-1:0] node_number;
        logic signed [VAL_W-1:0]  local_x;
        logic signed [VAL_W-1:0]  local_y;
    } t_in_word;

    typedef struct packed {
        logic        [NODE_W-1:0] out_node;
        logic                     dof_index;
        logic signed [VAL_W-1:0]  entry_value;
        logic        [SLOT_W-1:0] slot;
        logic        [STAT_W-1:0] status;
        logic                     last;
    } t_out_word;

    // search token walking down the cell row
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic             dof;
        logic             hit;
        logic [IDX_W-1:0] slot;
    } t_token;

    // append write broadcast to the row
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] slot;
        logic [KEY_W-1:0] key;
        logic             dof;
    } t_wr;

endpackage

`default_nettype wire

FILE: design/rigid_point_constraint_table_unit.sv
`default_nettype none

// Rigid point constraint table. Each input word is a node with marker-local
// coordinates; the block forms dx = shift_x - rotation*local_y and
// dy = shift_y + rotation*local_x (signed Q16.16, products rounded to nearest
// with ties up, sums saturated) and inserts keys (node,0) and (node,1) into a
// table of TABLE_DEPTH entries, giving two result words, x first. A known key
// reports status update and its slot; a new key is appended at the fill count;
// with the table full the key is dropped (status full, slot 0). Timing: one
// 32x32 multiplier is shared by both products, local_y first, then each key
// walks the row of TABLE_DEPTH cells, one cell per cycle. The x word is
// offered once the x key leaves the row; the y key enters the row once the x
// word moves to the output register, and the next input word is taken only
// after the y word has moved there, so a new word waits for both keys. A
// result word that cannot be handed over holds the block. Reset empties the
// table through the fill count; no sweep. Configuration (shift_x, shift_y,
// rotation at indexes 0..2) is written while idle: this binds the user, the
// block itself does not enforce it. Other indexes are ignored.

module rigid_point_constraint_table_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [rpct_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [rpct_pkg::VAL_W-1:0]        i_cfg_data,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire rpct_pkg::t_in_word          i_data,
    output logic                             o_valid,
    input  wire                              i_ready,
    output rpct_pkg::t_out_word              o_data
);
    import rpct_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MULY = 3'd1;
    localparam logic [2:0] S_MULX = 3'd2;
    localparam logic [2:0] S_SUMY = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    // config
    logic signed [VAL_W-1:0] r_shift_x;
    logic signed [VAL_W-1:0] r_shift_y;
    logic signed [VAL_W-1:0] r_rot;

    // current word
    logic [2:0]              r_state;
    logic [KEY_W-1:0]        r_key;
    logic signed [VAL_W-1:0] r_lx;
    logic signed [VAL_W-1:0] r_ly;
    logic signed [63:0]      r_prod;
    logic signed [VAL_W-1:0] r_dx;
    logic signed [VAL_W-1:0] r_dy;
    logic [CNT_W-1:0]        r_cnt;
    t_out_word               r_res;
    t_out_word               r_out;
    logic                    r_out_valid;

    t_token                  w_tok [0:TABLE_DEPTH];
    t_token                  w_head;
    t_token                  w_tail;
    t_wr                     w_wr;
    logic                    w_out_free;
    logic                    w_inject;
    logic signed [VAL_W-1:0] w_mul_b;
    logic signed [63:0]      w_prod;
    logic signed [47:0]      w_q;
    logic signed [48:0]      w_sum_x;
    logic signed [48:0]      w_sum_y;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [48:0] v);
        logic signed [VAL_W-1:0] res;
        if (v > 49'sh0_7FFF_FFFF) begin
            res = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (v < -49'sh0_8000_0000) begin
            res = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            res = VAL_W'(v);
        end
        return res;
    endfunction

    // one multiplier: local_y first, then local_x
    assign w_mul_b = (r_state == S_MULY) ? r_ly : r_lx;
    assign w_prod  = r_rot * w_mul_b;

    // Q32.32 -> Q16.16, round half up (floor of p + half)
    assign w_q     = 48'((r_prod + 64'sd32768) >>> 16);
    assign w_sum_x = 49'(r_shift_x) - 49'(w_q);
    assign w_sum_y = 49'(r_shift_y) + 49'(w_q);

    assign o_ready    = (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_ready;
    assign w_tail     = w_tok[TABLE_DEPTH];

    // x key starts after the products, y key once the x word is handed over
    assign w_inject = (r_state == S_SUMY) ||
                      ((r_state == S_EMIT) && w_out_free && !r_res.last);

    always_comb begin
        w_head       = '0;
        w_head.valid = w_inject;
        w_head.key   = r_key;
        w_head.dof   = (r_state == S_EMIT);
    end

    assign w_tok[0] = w_head;

    // a miss at the row end appends at the fill count while room is left
    always_comb begin
        w_wr      = '0;
        w_wr.en   = (r_state == S_SCAN) && w_tail.valid && !w_tail.hit &&
                    (r_cnt < CNT_W'(TABLE_DEPTH));
        w_wr.slot = r_cnt[IDX_W-1:0];
        w_wr.key  = w_tail.key;
        w_wr.dof  = w_tail.dof;
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            rpct_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_index (IDX_W'(g)),
                .i_count (r_cnt),
                .i_wr    (w_wr),
                .i_tok   (w_tok[g]),
                .o_tok   (w_tok[g+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_x <= '0;
            r_shift_y <= '0;
            r_rot     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SHIFT_X:  r_shift_x <= i_cfg_data;
                CFG_SHIFT_Y:  r_shift_y <= i_cfg_data;
                CFG_ROTATION: r_rot     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load wins over hand-over: the register is refilled at once
            if ((r_state == S_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_MULY;
                    end
                end
                S_MULY: r_state <= S_MULX;
                S_MULX: r_state <= S_SUMY;
                S_SUMY: r_state <= S_SCAN;
                S_SCAN: begin
                    if (w_tail.valid) begin
                        if (w_wr.en) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_state <= r_res.last ? S_IDLE : S_SCAN;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_key <= i_data.node_number[KEY_W-1:0];
                r_lx  <= i_data.local_x;
                r_ly  <= i_data.local_y;
            end
            S_MULY: r_prod <= w_prod;
            S_MULX: begin
                r_dx   <= sat32(w_sum_x);
                r_prod <= w_prod;
            end
            S_SUMY: r_dy <= sat32(w_sum_y);
            S_SCAN: begin
                if (w_tail.valid) begin
                    r_res.out_node    <= NODE_W'(w_tail.key);
                    r_res.dof_index   <= w_tail.dof;
                    r_res.entry_value <= w_tail.dof ? r_dy : r_dx;
                    r_res.last        <= w_tail.dof;
                    if (w_tail.hit) begin
                        r_res.status <= ST_UPDATE;
                        r_res.slot   <= SLOT_W'(w_tail.slot);
                    end else if (w_wr.en) begin
                        r_res.status <= ST_APPEND;
                        r_res.slot   <= SLOT_W'(r_cnt[IDX_W-1:0]);
                    end else begin
                        r_res.status <= ST_FULL;
                        r_res.slot   <= '0;
                    end
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    r_out <= r_res;
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

FILE: design/rpct_cell.sv
`default_nettype none

module rpct_cell (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire [rpct_pkg::IDX_W-1:0]  i_index,
    input  wire [rpct_pkg::CNT_W-1:0]  i_count,
    input  wire rpct_pkg::t_wr         i_wr,
    input  wire rpct_pkg::t_token      i_tok,
    output rpct_pkg::t_token           o_tok
);
    import rpct_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic             r_dof;
    t_token           r_tok;
    t_token           n_tok;
    logic             w_active;
    logic             w_match;

    // only slots below the fill count hold live keys
    assign w_active = CNT_W'(i_index) < i_count;
    assign w_match  = i_tok.valid && w_active && !i_tok.hit &&
                      (r_key == i_tok.key) && (r_dof == i_tok.dof);

    always_comb begin
        n_tok = i_tok;
        if (w_match) begin
            n_tok.hit  = 1'b1;
            n_tok.slot = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.slot == i_index)) begin
            r_key <= i_wr.key;
            r_dof <= i_wr.dof;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire
